// File: hdl/cle_pkg.sv
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the circular list engine: operation and
// status codes, and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cle_pkg;

    // Default sizing of the node store.
    localparam int CLE_CAPACITY   = 16;
    localparam int CLE_DATA_WIDTH = 32;

    // Request operation codes.
    typedef enum logic [2:0] {
        OP_INS_HEAD  = 3'd0,
        OP_INS_TAIL  = 3'd1,
        OP_INS_AFTER = 3'd2,
        OP_DEL_HEAD  = 3'd3,
        OP_DEL_TAIL  = 3'd4,
        OP_DEL_VALUE = 3'd5,
        OP_SEARCH    = 3'd6,
        OP_CLEAR     = 3'd7
    } t_op;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;    // take the request payload
        logic    walk_init;  // start a walk at the head
        logic    walk_step;  // move the walk on by one node
        logic    hit;        // keep the matching node and its successor
        logic    ins_setup;  // insert between tail and head
        logic    alloc;      // take a slot and write its value
        logic    link_new;   // write the link of the new node
        logic    link_pred;  // link the predecessor to the new node
        logic    unlink;     // bypass the node being removed
        logic    free_slot;  // return the removed node to the free list
        logic    clear;      // drop every element
        logic    set_st;     // record an error status
        t_status st;
        logic    load_out;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic empty;
        logic full;
        logic hit;
        logic last;
        logic out_busy;
    } t_stat;

endpackage

// File: hdl/cle_ifs.sv
// ----------------------------------------------------------------------------
// cle_ifs
// Valid/ready channels of the circular list engine: the request channel and
// the result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface cle_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op;
    logic signed [31:0] value;
    logic signed [31:0] anchor;

    modport source (output valid, output op, output value, output anchor, input ready);
    modport sink   (input valid, input op, input value, input anchor, output ready);
endinterface

interface cle_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [3:0] position;
    logic [4:0] length;
    logic       is_empty;

    modport source (output valid, output status, output position, output length,
                    output is_empty, input ready);
    modport sink   (input valid, input status, input position, input length,
                    input is_empty, output ready);
endinterface

// File: hdl/cle_ram.sv
// ----------------------------------------------------------------------------
// cle_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/cle_ctrl.sv
// ----------------------------------------------------------------------------
// cle_ctrl
// Controller of the circular list engine. Sequences one request at a time
// through dispatch, the list walk, the insert or remove steps and the
// hand-over to the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_ctrl import cle_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_DISPATCH = 9'b000000010,
        S_WALK     = 9'b000000100,
        S_INS_A    = 9'b000001000,
        S_INS_B    = 9'b000010000,
        S_INS_C    = 9'b000100000,
        S_DEL_A    = 9'b001000000,
        S_DEL_B    = 9'b010000000,
        S_FINISH   = 9'b100000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.op)
                    OP_INS_HEAD, OP_INS_TAIL: begin
                        if (i_stat.full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_FULL;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.ins_setup = 1'b1;
                            n_state         = S_INS_A;
                        end
                    end
                    OP_INS_AFTER: begin
                        if (i_stat.empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_EMPTY;
                            n_state      = S_FINISH;
                        end else if (i_stat.full) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_FULL;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                    OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_VALUE, OP_SEARCH: begin
                        if (i_stat.empty) begin
                            o_cmd.set_st = 1'b1;
                            o_cmd.st     = ST_EMPTY;
                            n_state      = S_FINISH;
                        end else begin
                            o_cmd.walk_init = 1'b1;
                            n_state         = S_WALK;
                        end
                    end
                    default: begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_FINISH;
                    end
                endcase
            end
            S_WALK: begin
                if (i_stat.hit) begin
                    o_cmd.hit = 1'b1;
                    if (i_stat.op == OP_INS_AFTER) begin
                        n_state = S_INS_A;
                    end else if (i_stat.op inside {OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_VALUE}) begin
                        n_state = S_DEL_A;
                    end else begin
                        n_state = S_FINISH;
                    end
                end else if (i_stat.last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = ST_NOT_FOUND;
                    n_state      = S_FINISH;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_INS_A: begin
                o_cmd.alloc = 1'b1;
                n_state     = S_INS_B;
            end
            S_INS_B: begin
                o_cmd.link_new = 1'b1;
                n_state        = S_INS_C;
            end
            S_INS_C: begin
                o_cmd.link_pred = 1'b1;
                n_state         = S_FINISH;
            end
            S_DEL_A: begin
                o_cmd.unlink = 1'b1;
                n_state      = S_DEL_B;
            end
            S_DEL_B: begin
                o_cmd.free_slot = 1'b1;
                n_state         = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/cle_datapath.sv
// ----------------------------------------------------------------------------
// cle_datapath
// Datapath of the circular list engine: node value and link memories, the
// head, tail, count and free-list registers, the walk cursor and the result
// register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_datapath import cle_pkg::*; #(
    parameter int CAPACITY   = CLE_CAPACITY,
    parameter int DATA_WIDTH = CLE_DATA_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [2:0]         i_op,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_anchor,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [3:0]         o_position,
    output logic [4:0]         o_length,
    output logic               o_is_empty
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Request and walk registers.
    t_op                   r_op;
    logic [DATA_WIDTH-1:0] r_val;
    logic [DATA_WIDTH-1:0] r_anc;
    t_status               r_status;
    logic [IDX_W-1:0]      r_pos;
    logic [IDX_W-1:0]      r_cur;
    logic [IDX_W-1:0]      r_prev;
    logic [IDX_W-1:0]      r_next;
    logic [IDX_W-1:0]      r_slot;
    logic [IDX_W-1:0]      r_k;
    logic                  r_pop;

    // List state. Slots are handed out from a fill count of never-used
    // slots or from a free list threaded through the link memory; the free
    // list holds r_fresh - r_count entries.
    logic [IDX_W-1:0]      r_head;
    logic [IDX_W-1:0]      r_tail;
    logic [IDX_W-1:0]      r_free_head;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_fresh;

    // Result register.
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [3:0]            r_out_pos;
    logic [4:0]            r_out_len;
    logic                  r_out_empty;

    logic [DATA_WIDTH+31:0] value_wide;
    logic [DATA_WIDTH+31:0] anchor_wide;
    logic [DATA_WIDTH-1:0]  key;
    logic [DATA_WIDTH-1:0]  value_rdata;
    logic [IDX_W-1:0]       link_rdata;
    logic [IDX_W-1:0]       raddr;
    logic                   link_we;
    logic [IDX_W-1:0]       link_waddr;
    logic [IDX_W-1:0]       link_wdata;
    logic [IDX_W-1:0]       alloc_slot;
    logic                   pop_now;
    logic                   empty;
    logic                   full;
    logic                   many;
    logic                   last;
    logic                   hit;
    logic [IDX_W+3:0]       pos_wide;
    logic [CNT_W+4:0]       len_wide;

    // Values are sign-extended from 32 bits and kept in DATA_WIDTH bits.
    assign value_wide  = {{DATA_WIDTH{i_value[31]}}, i_value};
    assign anchor_wide = {{DATA_WIDTH{i_anchor[31]}}, i_anchor};
    assign key         = (r_op == OP_INS_AFTER) ? r_anc : r_val;

    assign empty   = (r_count == '0);
    assign full    = (r_count == CNT_W'(CAPACITY));
    assign many    = (r_count > CNT_W'(1));
    assign last    = ((CNT_W'(r_k) + CNT_W'(1)) == r_count);
    assign pop_now = (r_fresh != r_count);

    assign alloc_slot = pop_now ? r_free_head : r_fresh[IDX_W-1:0];

    // Match condition of the walk for each operation.
    always_comb begin
        case (r_op)
            OP_DEL_HEAD:                           hit = 1'b1;
            OP_DEL_TAIL:                           hit = last;
            OP_INS_AFTER, OP_DEL_VALUE, OP_SEARCH: hit = (value_rdata == key);
            default:                               hit = 1'b0;
        endcase
    end

    assign o_stat.op       = r_op;
    assign o_stat.empty    = empty;
    assign o_stat.full     = full;
    assign o_stat.hit      = hit;
    assign o_stat.last     = last;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;

    // Read address: the walk follows the link just read, allocation reads
    // the link of the first free slot, otherwise the head.
    always_comb begin
        if (i_cmd.walk_step) begin
            raddr = link_rdata;
        end else if (i_cmd.alloc) begin
            raddr = r_free_head;
        end else begin
            raddr = r_head;
        end
    end

    // Link memory write selection.
    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_slot;
        link_wdata = r_next;
        if (i_cmd.link_new) begin
            link_we    = 1'b1;
            link_waddr = r_slot;
            link_wdata = empty ? r_slot : r_next;
        end else if (i_cmd.link_pred) begin
            link_we    = !empty;
            link_waddr = r_cur;
            link_wdata = r_slot;
        end else if (i_cmd.unlink) begin
            link_we    = many;
            link_waddr = r_prev;
            link_wdata = r_next;
        end else if (i_cmd.free_slot) begin
            link_we    = 1'b1;
            link_waddr = r_cur;
            link_wdata = r_free_head;
        end
    end

    cle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.alloc),
        .i_waddr (alloc_slot),
        .i_wdata (r_val),
        .i_raddr (raddr),
        .o_rdata (value_rdata)
    );

    cle_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_rdata)
    );

    // List state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_free_head <= '0;
            r_count     <= '0;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_count <= '0;
                r_fresh <= '0;
                r_tail  <= '0;
            end
            if (i_cmd.alloc && !pop_now) begin
                r_fresh <= r_fresh + CNT_W'(1);
            end
            if (i_cmd.link_new && r_pop) begin
                r_free_head <= link_rdata;
            end
            if (i_cmd.link_pred) begin
                if (empty) begin
                    r_head <= r_slot;
                    r_tail <= r_slot;
                end else begin
                    case (r_op)
                        OP_INS_HEAD: r_head <= r_slot;
                        OP_INS_TAIL: r_tail <= r_slot;
                        OP_INS_AFTER: begin
                            if (r_cur == r_tail) begin
                                r_tail <= r_slot;
                            end
                        end
                        default: ;
                    endcase
                end
                r_count <= r_count + CNT_W'(1);
            end
            if (i_cmd.unlink) begin
                if (many) begin
                    if (r_cur == r_tail) begin
                        r_tail <= r_prev;
                    end
                    if (r_cur == r_head) begin
                        r_head <= r_next;
                    end
                end else begin
                    r_tail <= '0;
                end
            end
            if (i_cmd.free_slot) begin
                r_free_head <= r_cur;
                r_count     <= r_count - CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request payload, walk cursor and result payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= t_op'(i_op);
            r_val    <= value_wide[DATA_WIDTH-1:0];
            r_anc    <= anchor_wide[DATA_WIDTH-1:0];
            r_status <= ST_OK;
            r_pos    <= '0;
        end
        if (i_cmd.set_st) begin
            r_status <= i_cmd.st;
        end
        if (i_cmd.walk_init) begin
            r_cur  <= r_head;
            r_prev <= r_tail;
            r_k    <= '0;
        end
        if (i_cmd.walk_step) begin
            r_prev <= r_cur;
            r_cur  <= link_rdata;
            r_k    <= r_k + IDX_W'(1);
        end
        if (i_cmd.hit) begin
            r_next <= link_rdata;
            r_pos  <= (r_op == OP_INS_AFTER) ? (r_k + IDX_W'(1)) : r_k;
        end
        if (i_cmd.ins_setup) begin
            r_cur  <= r_tail;
            r_next <= r_head;
            r_pos  <= (r_op == OP_INS_TAIL) ? r_count[IDX_W-1:0] : '0;
        end
        if (i_cmd.alloc) begin
            r_slot <= alloc_slot;
            r_pop  <= pop_now;
        end
        if (i_cmd.load_out) begin
            r_out_status <= r_status;
            r_out_pos    <= pos_wide[3:0];
            r_out_len    <= len_wide[4:0];
            r_out_empty  <= empty;
        end
    end

    assign pos_wide = {4'b0, r_pos};
    assign len_wide = {5'b0, r_count};

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_position  = r_out_pos;
    assign o_length    = r_out_len;
    assign o_is_empty  = r_out_empty;

endmodule

// File: hdl/circular_list_engine_core.sv
// Per request: a failed size check or a clear goes from dispatch to the result load,
// insert at the head or tail runs the insert steps, and search, delete and insert
// after walk the list one node per cycle, delete and insert after then running the
// remove or insert steps; delete at the head walks one node, delete at the tail all.
// Throughput: one request at a time, the next transfer follows the result load.
// Reset: synchronous active low; the list is empty after reset.
// ----------------------------------------------------------------------------
// circular_list_engine_core
// Bounded circular singly linked list engine: one list operation per request,
// one result per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_list_engine_core import cle_pkg::*; #(
    parameter int CAPACITY   = CLE_CAPACITY,
    parameter int DATA_WIDTH = CLE_DATA_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cle_req_if.sink     i_req,
    cle_rsp_if.source   o_rsp
);

    t_cmd  cmd;
    t_stat stat;

    // Request sequencing.
    cle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // List storage and result register.
    cle_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_req.op),
        .i_value     (i_req.value),
        .i_anchor    (i_req.anchor),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_position  (o_rsp.position),
        .o_length    (o_rsp.length),
        .o_is_empty  (o_rsp.is_empty)
    );

endmodule

// File: hdl/cle_checker.sv
// ----------------------------------------------------------------------------
// cle_checker
// Port-level checks of the circular list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_checker import cle_pkg::*; #(
    parameter int CAPACITY = CLE_CAPACITY
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [3:0] i_position,
    input logic [4:0] i_length,
    input logic       i_is_empty
);

    localparam logic [4:0] CAP_LEN = 5'(CAPACITY);

    // The empty flag agrees with the reported length.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_is_empty == (i_length == 5'd0)))
        else $error("is_empty disagrees with length");

    // A failed request reports position zero, and an empty list has no length.
    a_fail_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status != ST_OK)) |->
        ((i_position == 4'd0) && ((i_status != ST_EMPTY) || (i_length == 5'd0))))
        else $error("failed request with non-zero position or length");

    // A full status is only given with the list at capacity.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_status == ST_FULL)) |-> (i_length == CAP_LEN))
        else $error("full status below capacity");

    // One request at a time: no transfer in the cycle after a transfer.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while another is in progress");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_status) && $stable(i_position) &&
         $stable(i_length) && $stable(i_is_empty)))
        else $error("stalled result changed");

endmodule

bind circular_list_engine_core cle_checker #(
    .CAPACITY (CAPACITY)
) u_cle_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_status    (o_rsp.status),
    .i_position  (o_rsp.position),
    .i_length    (o_rsp.length),
    .i_is_empty  (o_rsp.is_empty)
);
